### sv/sdu_pkg.sv
// sdu_pkg: types and constants shared by the data unstuffer
// result record, line states, header word tables, character codes
`default_nettype none

package sdu_pkg;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_DOT = 8'h2e;

    localparam logic       CFG_BYTE_LIMIT = 1'b0;
    localparam logic       CFG_HOP_LIMIT  = 1'b1;
    localparam logic [7:0] HOP_LIMIT_RST  = 8'd100;

    localparam logic [3:0] DLV_LEN = 4'd9;
    localparam logic [3:0] RCV_LEN = 4'd8;

    localparam logic [7:0] DLV_LO [0:8] = '{8'h64, 8'h65, 8'h6c, 8'h69, 8'h76,
                                            8'h65, 8'h72, 8'h65, 8'h64};
    localparam logic [7:0] DLV_UP [0:8] = '{8'h44, 8'h45, 8'h4c, 8'h49, 8'h56,
                                            8'h45, 8'h52, 8'h45, 8'h44};
    localparam logic [7:0] RCV_LO [0:7] = '{8'h72, 8'h65, 8'h63, 8'h65, 8'h69,
                                            8'h76, 8'h65, 8'h64};
    localparam logic [7:0] RCV_UP [0:7] = '{8'h52, 8'h45, 8'h43, 8'h45, 8'h49,
                                            8'h56, 8'h45, 8'h44};

    typedef enum logic [2:0] {
        LS_MID   = 3'd0,
        LS_START = 3'd1,
        LS_DOT   = 3'd2,
        LS_DOTCR = 3'd3,
        LS_CR    = 3'd4
    } t_line_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       too_many_hops;
        logic       size_exceeded;
        logic       last;
    } t_result;

    typedef struct packed {
        logic step;
        logic clear;
    } t_hdr_ctl;

endpackage

`default_nettype wire

### sv/sdu_in_if.sv
// sdu_in_if: request channel carrying raw data bytes
// valid/ready handshake, no dependencies
`default_nettype none

interface sdu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

### sv/sdu_out_if.sv
// sdu_out_if: result channel of the data unstuffer
// valid/ready handshake, no dependencies
`default_nettype none

interface sdu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       too_many_hops;
    logic       size_exceeded;
    logic       last;

    modport source (output valid, output kind, output data_byte, output too_many_hops,
                    output size_exceeded, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input too_many_hops,
                    input size_exceeded, input last, output ready);
endinterface

`default_nettype wire

### sv/sdu_hdr.sv
// sdu_hdr: header line tracker, counts received/delivered lines up to the blank line
// depends on sdu_pkg
`default_nettype none

module sdu_hdr (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sdu_pkg::t_hdr_ctl i_ctl,
    input  wire logic [7:0]        i_ch,
    output logic [7:0]             o_hop_count
);
    import sdu_pkg::*;

    logic       r_in_header, n_in_header;
    logic [3:0] r_column, n_column;
    logic       r_maybe_rcv, n_maybe_rcv;
    logic       r_maybe_dlv, n_maybe_dlv;
    logic       r_maybe_blank, n_maybe_blank;
    logic [7:0] r_hop, n_hop;

    always_comb begin
        logic inc;
        inc           = 1'b0;
        n_in_header   = r_in_header;
        n_column      = r_column;
        n_maybe_rcv   = r_maybe_rcv;
        n_maybe_dlv   = r_maybe_dlv;
        n_maybe_blank = r_maybe_blank;
        n_hop         = r_hop;
        if (r_in_header) begin
            if (r_column < DLV_LEN) begin
                if (i_ch != DLV_LO[r_column] && i_ch != DLV_UP[r_column]) begin
                    n_maybe_dlv = 1'b0;
                end
                if (n_maybe_dlv && r_column == 4'd8) begin
                    inc = 1'b1;
                end
                if (r_column < RCV_LEN) begin
                    if (i_ch != RCV_LO[r_column[2:0]] && i_ch != RCV_UP[r_column[2:0]]) begin
                        n_maybe_rcv = 1'b0;
                    end
                end
                if (n_maybe_rcv && r_column == 4'd7) begin
                    inc = 1'b1;
                end
                if (r_column == 4'd0 && i_ch != CH_CR) begin
                    n_maybe_blank = 1'b0;
                end
                if (r_column == 4'd1 && i_ch != CH_LF) begin
                    n_maybe_blank = 1'b0;
                end
                if (n_maybe_blank && r_column == 4'd1) begin
                    n_in_header = 1'b0;
                end
                n_column = r_column + 4'd1;
            end
            if (i_ch == CH_LF) begin
                n_column      = 4'd0;
                n_maybe_rcv   = 1'b1;
                n_maybe_dlv   = 1'b1;
                n_maybe_blank = 1'b1;
            end
        end
        if (inc && r_hop != 8'hff) begin
            n_hop = r_hop + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_in_header   <= 1'b1;
            r_column      <= 4'd0;
            r_maybe_rcv   <= 1'b1;
            r_maybe_dlv   <= 1'b1;
            r_maybe_blank <= 1'b1;
            r_hop         <= 8'd0;
        end else if (i_ctl.step) begin
            r_in_header   <= n_in_header;
            r_column      <= n_column;
            r_maybe_rcv   <= n_maybe_rcv;
            r_maybe_dlv   <= n_maybe_dlv;
            r_maybe_blank <= n_maybe_blank;
            r_hop         <= n_hop;
        end
    end

    assign o_hop_count = r_hop;

endmodule

`default_nettype wire

### sv/smtp_data_unstuffer.sv
// smtp_data_unstuffer: removes dot-stuffing, maps CRLF to LF, finds the end line
// a request is captured in the input register, then its results in the result register
// throughput: one byte per cycle while the output is ready; a byte with 2 or 3 results holds the input
// register until its last result is taken from the three-entry result register
// reset (synchronous, active low): message state cleared, byte_limit 0, hop_limit 100
// depends on sdu_pkg, sdu_in_if, sdu_out_if, sdu_hdr
`default_nettype none

module smtp_data_unstuffer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    sdu_in_if.sink           i_req,
    sdu_out_if.source        o_res
);
    import sdu_pkg::*;

    logic [31:0]  r_load_val;
    logic [7:0]   r_hop_limit;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;

    t_line_state  r_line, n_line;
    logic         r_fresh;
    logic [31:0]  r_bytes_left, n_bytes_left;
    logic         r_size_over, n_size_over;

    t_result      r_slot [0:2];
    t_result      n_slot [0:2];
    logic [1:0]   r_cnt, n_cnt;

    logic         msg_done;
    logic         take;
    logic         buf_free;
    logic         load;
    logic [7:0]   hop_count;
    t_hdr_ctl     hdr_ctl;

    function automatic t_result f_data(input logic [7:0] b);
        t_result r;
        r           = '0;
        r.kind      = KIND_DATA;
        r.data_byte = b;
        return r;
    endfunction

    // config, load value precomputed from byte_limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_val  <= 32'd0;
            r_hop_limit <= HOP_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BYTE_LIMIT: begin
                    if (i_cfg_data == 32'd0) begin
                        r_load_val <= 32'd0;
                    end else if (i_cfg_data == 32'hffff_ffff) begin
                        r_load_val <= 32'hffff_ffff;
                    end else begin
                        r_load_val <= i_cfg_data + 32'd1;
                    end
                end
                CFG_HOP_LIMIT: begin
                    r_hop_limit <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign take     = (r_cnt != 2'd0) && o_res.ready;
    assign buf_free = (r_cnt == 2'd0) || (take && r_cnt == 2'd1);
    assign load     = r_in_valid && buf_free;
    assign i_req.ready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte <= i_req.in_byte;
        end
    end

    always_comb begin
        logic [7:0]  ch;
        logic [1:0]  k_data;
        logic [31:0] eff_left;
        t_result     end_res;
        ch       = r_in_byte;
        k_data   = 2'd0;
        msg_done = 1'b0;
        n_line   = r_line;
        n_cnt    = 2'd0;
        for (int i = 0; i < 3; i++) begin
            n_slot[i] = '0;
        end
        end_res               = '0;
        end_res.kind          = KIND_END;
        end_res.too_many_hops = (hop_count >= r_hop_limit);
        end_res.size_exceeded = r_size_over;

        unique case (r_line)
            LS_START, LS_DOT: begin
                if (ch == CH_LF) begin
                    n_slot[0].kind = KIND_ABORT;
                    n_cnt          = 2'd1;
                    msg_done       = 1'b1;
                end else if (ch == CH_DOT && r_line == LS_START) begin
                    n_line = LS_DOT;
                end else if (ch == CH_CR) begin
                    n_line = (r_line == LS_START) ? LS_CR : LS_DOTCR;
                end else begin
                    n_line    = LS_MID;
                    n_slot[0] = f_data(ch);
                    n_cnt     = 2'd1;
                    k_data    = 2'd1;
                end
            end
            LS_DOTCR: begin
                if (ch == CH_LF) begin
                    n_slot[0] = end_res;
                    n_cnt     = 2'd1;
                    msg_done  = 1'b1;
                end else begin
                    n_slot[0] = f_data(CH_DOT);
                    n_slot[1] = f_data(CH_CR);
                    if (ch == CH_CR) begin
                        n_line = LS_CR;
                        n_cnt  = 2'd2;
                        k_data = 2'd2;
                    end else begin
                        n_line    = LS_MID;
                        n_slot[2] = f_data(ch);
                        n_cnt     = 2'd3;
                        k_data    = 2'd3;
                    end
                end
            end
            LS_CR: begin
                if (ch == CH_LF) begin
                    n_line    = LS_START;
                    n_slot[0] = f_data(ch);
                    n_cnt     = 2'd1;
                    k_data    = 2'd1;
                end else if (ch == CH_CR) begin
                    n_slot[0] = f_data(ch);
                    n_cnt     = 2'd1;
                    k_data    = 2'd1;
                end else begin
                    n_line    = LS_MID;
                    n_slot[0] = f_data(CH_CR);
                    n_slot[1] = f_data(ch);
                    n_cnt     = 2'd2;
                    k_data    = 2'd2;
                end
            end
            default: begin
                if (ch == CH_LF) begin
                    n_slot[0].kind = KIND_ABORT;
                    n_cnt          = 2'd1;
                    msg_done       = 1'b1;
                end else if (ch == CH_CR) begin
                    n_line = LS_CR;
                end else begin
                    n_line    = LS_MID;
                    n_slot[0] = f_data(ch);
                    n_cnt     = 2'd1;
                    k_data    = 2'd1;
                end
            end
        endcase

        for (int i = 0; i < 3; i++) begin
            n_slot[i].last = (n_cnt == 2'(i + 1));
        end

        // size budget
        eff_left     = r_fresh ? r_load_val : r_bytes_left;
        n_bytes_left = eff_left;
        n_size_over  = r_size_over;
        if (eff_left != 32'd0 && k_data != 2'd0) begin
            if (eff_left <= {30'd0, k_data}) begin
                n_bytes_left = 32'd0;
                n_size_over  = 1'b1;
            end else begin
                n_bytes_left = eff_left - {30'd0, k_data};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= LS_START;
            r_fresh      <= 1'b1;
            r_bytes_left <= 32'd0;
            r_size_over  <= 1'b0;
        end else if (load) begin
            if (msg_done) begin
                r_line       <= LS_START;
                r_fresh      <= 1'b1;
                r_bytes_left <= 32'd0;
                r_size_over  <= 1'b0;
            end else begin
                r_line       <= n_line;
                r_fresh      <= 1'b0;
                r_bytes_left <= n_bytes_left;
                r_size_over  <= n_size_over;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= n_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot[0] <= n_slot[0];
            r_slot[1] <= n_slot[1];
            r_slot[2] <= n_slot[2];
        end else if (take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    assign hdr_ctl.step  = load;
    assign hdr_ctl.clear = load && msg_done;

    sdu_hdr u_hdr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (hdr_ctl),
        .i_ch        (r_in_byte),
        .o_hop_count (hop_count)
    );

    assign o_res.valid         = (r_cnt != 2'd0);
    assign o_res.kind          = r_slot[0].kind;
    assign o_res.data_byte     = r_slot[0].data_byte;
    assign o_res.too_many_hops = r_slot[0].too_many_hops;
    assign o_res.size_exceeded = r_slot[0].size_exceeded;
    assign o_res.last          = r_slot[0].last;

endmodule

`default_nettype wire
